// ===== rtl/core/iadb_pkg.sv =====
// Package for the IMA ADPCM byte decoder: nibble operation type, step table
// and index limits. No dependencies.

package iadb_pkg;

   // Highest legal step index
   localparam logic [6:0] IDX_MAX = 7'd88;

   // Saturation limits of the predictor
   localparam logic signed [17:0] PCM_MAX = 18'sd32767;
   localparam logic signed [17:0] PCM_MIN = -18'sd32768;

   // Standard IMA ADPCM step table, 89 entries
   localparam logic [14:0] STEP_TABLE [89] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // One nibble to decode, as passed from the front to the back
   typedef struct packed {
      logic [3:0]         code;
      logic               start;
      logic signed [15:0] init_sample;
      logic [6:0]         init_index;
      logic               pair_last;
      logic               block_end;
   } op_type;

endpackage

// ===== rtl/core/iadb_front.sv =====
// Front of the IMA ADPCM byte decoder: holds one code byte and splits it
// into two nibble operations, high nibble first. Depends on iadb_pkg.

module iadb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_code_byte,
   input  logic                req_start_block,
   input  logic signed [15:0]  req_initial_sample,
   input  logic [7:0]          req_initial_step_index,
   input  logic                req_last_byte,
   output logic                op_valid,
   input  logic                op_ready,
   output iadb_pkg::op_type    op
);

   logic               hold_valid_ff, hold_valid_in;
   logic               phase_ff, phase_in;
   logic [7:0]         byte_ff;
   logic               start_ff;
   logic signed [15:0] init_sample_ff;
   logic [6:0]         init_index_ff;
   logic               last_ff;
   logic               take;

   // Accept a new byte when empty or when the low nibble leaves this cycle
   assign req_ready = !hold_valid_ff || (phase_ff && op_ready);
   assign take      = req_valid && req_ready;

   // Advance the nibble phase and the hold flag
   always_comb begin
      hold_valid_in = hold_valid_ff;
      phase_in      = phase_ff;
      if (hold_valid_ff && op_ready) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in      = 1'b0;
            hold_valid_in = 1'b0;
         end
      end
      if (take) begin
         hold_valid_in = 1'b1;
         phase_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
      end
   end

   // Capture the byte and clamp the starting index
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff        <= req_code_byte;
         start_ff       <= req_start_block;
         init_sample_ff <= req_initial_sample;
         init_index_ff  <= (req_initial_step_index > {1'b0, iadb_pkg::IDX_MAX}) ?
                           iadb_pkg::IDX_MAX : req_initial_step_index[6:0];
         last_ff        <= req_last_byte;
      end
   end

   // Build the nibble operation for the current phase
   always_comb begin
      op_valid       = hold_valid_ff;
      op.code        = phase_ff ? byte_ff[3:0] : byte_ff[7:4];
      op.start       = start_ff && !phase_ff;
      op.init_sample = init_sample_ff;
      op.init_index  = init_index_ff;
      op.pair_last   = phase_ff;
      op.block_end   = last_ff && phase_ff;
   end

endmodule

// ===== rtl/core/iadb_fifo.sv =====
// Short queue of nibble operations between the front and the back of the
// IMA ADPCM byte decoder. Depends on iadb_pkg.

module iadb_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  iadb_pkg::op_type    push_op,
   output logic                pop_valid,
   input  logic                pop_ready,
   output iadb_pkg::op_type    pop_op
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   iadb_pkg::op_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_op     = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed operation
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/iadb_back.sv =====
// Back of the IMA ADPCM byte decoder: one nibble per cycle unless stalled, keeps
// predictor and step index, drives the result register. Depends on iadb_pkg.

module iadb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   output logic                op_ready,
   input  iadb_pkg::op_type    op,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_pcm_sample,
   output logic                rsp_pair_last,
   output logic                rsp_block_end
);

   logic signed [15:0] pred_ff, pred_in;
   logic [6:0]         index_ff, index_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] sample_ff;
   logic               pair_last_ff;
   logic               block_end_ff;

   logic               take;
   logic signed [15:0] pred_cur;
   logic [6:0]         index_cur;
   logic [14:0]        step;
   logic [16:0]        diff;
   logic signed [17:0] pred_x, diff_x, sum;
   logic signed [7:0]  adj, index_sum;

   // Take an operation when the result register is free or being drained
   assign op_ready = !out_valid_ff || rsp_ready;
   assign take     = op_valid && op_ready;

   // Decode one nibble
   always_comb begin
      pred_cur  = op.start ? op.init_sample : pred_ff;
      index_cur = op.start ? op.init_index : index_ff;
      step      = iadb_pkg::STEP_TABLE[index_cur];

      diff = 17'(step >> 3);
      if (op.code[2]) begin
         diff = diff + 17'(step);
      end
      if (op.code[1]) begin
         diff = diff + 17'(step >> 1);
      end
      if (op.code[0]) begin
         diff = diff + 17'(step >> 2);
      end

      pred_x = 18'(pred_cur);
      diff_x = signed'({1'b0, diff});
      sum    = op.code[3] ? (pred_x - diff_x) : (pred_x + diff_x);
      if (sum > iadb_pkg::PCM_MAX) begin
         pred_in = 16'sh7fff;
      end else if (sum < iadb_pkg::PCM_MIN) begin
         pred_in = 16'sh8000;
      end else begin
         pred_in = sum[15:0];
      end

      adj       = op.code[2] ? (signed'({5'b0, op.code[1:0], 1'b0}) + 8'sd2) : -8'sd1;
      index_sum = signed'({1'b0, index_cur}) + adj;
      if (index_sum < 8'sd0) begin
         index_in = '0;
      end else if (index_sum > signed'({1'b0, iadb_pkg::IDX_MAX})) begin
         index_in = iadb_pkg::IDX_MAX;
      end else begin
         index_in = index_sum[6:0];
      end
   end

   // Hold or drop the result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff      <= '0;
         index_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            pred_ff  <= pred_in;
            index_ff <= index_in;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff    <= pred_in;
         pair_last_ff <= op.pair_last;
         block_end_ff <= op.block_end;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pcm_sample = sample_ff;
   assign rsp_pair_last  = pair_last_ff;
   assign rsp_block_end  = block_end_ff;

endmodule

// ===== rtl/core/ima_adpcm_byte_decoder_top.sv =====
// IMA ADPCM byte decoder, top level: front, nibble queue and decode back.
// Depends on iadb_pkg, iadb_front, iadb_fifo and iadb_back.

// Each code byte yields two 16-bit samples, high nibble first; the second
// carries pair_last, and on a byte marked last_byte also block_end. A byte
// with start_block loads the predictor and the step index (clamped to 88)
// before its first nibble; otherwise decoding continues from the state left
// by the previous byte. Unless stalled, the back decodes one nibble per
// cycle, since each nibble needs the predictor and index left by the one
// before. A byte can be taken while the previous one is still being split;
// the nibble queue and the result register let input and output stall on
// their own. The first sample of a byte passes the front's byte register,
// the nibble queue and the result register before it is offered.

module ima_adpcm_byte_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_code_byte,
   input  logic               req_start_block,
   input  logic signed [15:0] req_initial_sample,
   input  logic [7:0]         req_initial_step_index,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_pair_last,
   output logic               rsp_block_end
);

   logic             push_valid, push_ready;
   logic             pop_valid, pop_ready;
   iadb_pkg::op_type push_op, pop_op;

   // Split bytes into nibble operations
   iadb_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_code_byte          (req_code_byte),
      .req_start_block        (req_start_block),
      .req_initial_sample     (req_initial_sample),
      .req_initial_step_index (req_initial_step_index),
      .req_last_byte          (req_last_byte),
      .op_valid               (push_valid),
      .op_ready               (push_ready),
      .op                     (push_op)
   );

   // Queue nibble operations
   iadb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Decode nibbles into samples
   iadb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (pop_valid),
      .op_ready       (pop_ready),
      .op             (pop_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pcm_sample (rsp_pcm_sample),
      .rsp_pair_last  (rsp_pair_last),
      .rsp_block_end  (rsp_block_end)
   );

   // A freshly accepted byte offers its high nibble first
   a_high_first : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> push_valid && !push_op.pair_last)
      else $error("accepted byte did not offer its high nibble next");

   // A reload only travels with the high nibble
   a_start_high : assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_op.start |-> !pop_op.pair_last)
      else $error("start reload attached to a low nibble");

   // Block end only on the second sample of a pair
   a_end_pair : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_pair_last)
      else $error("block end flagged on a high-nibble sample");

endmodule
